// File: sv/mbps_pkg.sv
// Shared types and constants for the multichannel beat phasor sequencer.
// No dependencies.
package mbps_pkg;
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_CLEAR  = 3'd2;
  localparam logic [2:0] ACT_PLAY   = 3'd3;
  localparam logic [2:0] ACT_PAUSE  = 3'd4;
  localparam logic [2:0] ACT_STOP   = 3'd5;
  localparam logic [2:0] ACT_SEEK   = 3'd6;

  localparam int unsigned SAMP_W = 24;
  localparam logic [SAMP_W-1:0] SAMP_MAX = 24'hFFFFFF;
  localparam logic [SAMP_W-1:0] SAMP_RESET = 24'd44100;
  localparam logic [17:0] RATE_RESET = 18'd44100;
  localparam logic [15:0] PHASE_DEAD = 16'h8000;
  localparam logic [15:0] PHASE_SAT = 16'h7FFF;
  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  channel;
    logic [15:0] beat_ms;
    logic [25:0] position_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic [15:0] phase;
    logic        beat_event;
    logic        last;
  } res_t;
endpackage

// File: sv/mbps_req_if.sv
// Valid/ready channel carrying one request or one result.
// Depends on mbps_pkg.
interface mbps_req_if #(parameter type T = mbps_pkg::req_t);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/mbps_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module mbps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// File: sv/multichannel_beat_phasor_sequencer_unit.sv
// Multichannel beat phasor sequencer: one request at a time, bit-serial math.
// Tick, per channel: a 44-step divide, or on a beat advance a read, a 26-step
// multiply and a 44-step divide; no math when paused or dead; results may stall.
// Pause and stop step through every channel, append one, and seek walks each channel's beats.
// Clear and play need no math; the next request is taken once the last one is done.
// Reset (async, low) empties every list logically (counts 0), all dead and paused.
module multichannel_beat_phasor_sequencer_unit #(
  parameter int unsigned NUM_CHANNELS   = 8,
  parameter int unsigned MAX_BEAT_COUNT = 1024,
  parameter int unsigned BEAT_MS_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [17:0] cfg_wdata_i,
  mbps_req_if.sink    req_i,
  mbps_req_if.source  res_o
);
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned PW = $clog2(MAX_BEAT_COUNT);
  localparam int unsigned NW = PW + 1;
  localparam int unsigned DEPTH = NUM_CHANNELS * MAX_BEAT_COUNT;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = mbps_pkg::SAMP_W;
  localparam int unsigned PRW = 26 + 18;  // product width ms*rate
  localparam int unsigned PCW = $clog2(PRW + 1);

  // States
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CH    = 4'd1;  // start one channel's work
  localparam logic [3:0] S_RD    = 4'd2;  // RAM read latency
  localparam logic [3:0] S_MUL   = 4'd3;  // serial ms*rate
  localparam logic [3:0] S_DIV   = 4'd4;  // serial divide
  localparam logic [3:0] S_FIN   = 4'd5;  // apply a divide result
  localparam logic [3:0] S_OUT   = 4'd6;  // present result
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_SKACC = 4'd8;  // seek: accumulate beat
  localparam logic [3:0] S_LD    = 4'd9;  // read data valid, load multiplier
  // divide purposes
  localparam logic [1:0] DV_SAMP  = 2'd0; // ms*rate/1000 -> arm
  localparam logic [1:0] DV_PHASE = 2'd1; // countdown<<15 / samples
  localparam logic [1:0] DV_OFF   = 2'd2; // seek offset samples

  logic [3:0] st_q, st_d;
  mbps_pkg::req_t rq_q;
  logic [17:0] rate_q;
  logic running_q;
  logic [NW-1:0] cnt_q [NUM_CHANNELS];
  logic [PW-1:0] pos_q [NUM_CHANNELS];
  logic [SW-1:0] cd_q [NUM_CHANNELS];
  logic [SW-1:0] bs_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] fin_q;
  logic [15:0] held_q [NUM_CHANNELS];
  logic [CW-1:0] ch_q;
  logic [NW-1:0] bi_q;             // seek walk index
  logic [26:0] acc_q, prev_q;      // seek sums (capped use)
  logic [1:0] dv_q;
  logic [PRW-1:0] mplier_q, mcand_q, prod_q;
  logic [5:0] mcnt_q;
  logic [PRW-1:0] dnum_q;
  logic [SW-1:0] dden_q;
  logic [PRW:0] rem_q;
  logic [PRW-1:0] quo_q;
  logic [PCW-1:0] dcnt_q;
  logic [SW-1:0] sarm_q;           // samples of arm during seek
  mbps_pkg::res_t res_q;
  logic res_v_q;
  logic [PW-1:0] arm_pos_q;

  // store
  logic we;
  logic [AW-1:0] ram_a;
  logic [15:0] ram_rd;
  logic [15:0] ms_w;
  assign ms_w = rq_q.beat_ms & 16'((32'd1 << BEAT_MS_BITS) - 1);
  mbps_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
    .clk_i(clk_i), .we_i(we), .addr_i(ram_a), .wdata_i(ms_w), .rdata_o(ram_rd)
  );

  logic ch_ok;
  assign ch_ok = 32'(rq_q.channel) < NUM_CHANNELS;
  logic [CW-1:0] rq_ch;
  assign rq_ch = CW'(rq_q.channel);
  // beat index read: walk index on seek, arm position otherwise
  logic [PW-1:0] rd_idx;
  assign rd_idx = (rq_q.action == mbps_pkg::ACT_SEEK) ? bi_q[PW-1:0] : arm_pos_q;
  assign we = (st_q == S_CH) && rq_q.action == mbps_pkg::ACT_APPEND && ch_ok
              && cnt_q[rq_ch] < NW'(MAX_BEAT_COUNT);
  always_comb begin
    if (rq_q.action == mbps_pkg::ACT_APPEND && st_q == S_CH) begin
      ram_a = AW'({rq_ch, cnt_q[rq_ch][PW-1:0]});
    end else begin
      ram_a = AW'({ch_q, rd_idx});
    end
  end
  // beat ms valid only inside the list
  logic in_list;
  logic [NW-1:0] idx_ext;
  assign idx_ext = (rq_q.action == mbps_pkg::ACT_SEEK) ? bi_q : {1'b0, arm_pos_q};
  assign in_list = idx_ext < cnt_q[ch_q];
  logic [15:0] beat_ms_rd;
  assign beat_ms_rd = in_list ? ram_rd : 16'd0;

  // serial divide step
  logic [PRW:0] rem_sh;
  assign rem_sh = {rem_q[PRW-1:0], dnum_q[PRW-1]};
  logic ge;
  assign ge = rem_sh >= (PRW+1)'(dden_q);
  logic [SW-1:0] samp_of_q;
  assign samp_of_q = (quo_q > PRW'(mbps_pkg::SAMP_MAX)) ? mbps_pkg::SAMP_MAX : quo_q[SW-1:0];
  logic [15:0] ph_of_q;
  assign ph_of_q = (quo_q > PRW'(32767)) ? mbps_pkg::PHASE_SAT : quo_q[15:0];

  logic last_ch;
  assign last_ch = ch_q == CW'(NUM_CHANNELS - 1);

  assign req_i.ready = (st_q == S_IDLE);
  assign res_o.valid = res_v_q;
  assign res_o.data = res_q;

  logic [26:0] acc_nx;
  assign acc_nx = acc_q + 27'(beat_ms_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      rate_q <= mbps_pkg::RATE_RESET;
      running_q <= 1'b0;
      fin_q <= '1;
      res_v_q <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        cnt_q[c] <= '0;
        pos_q[c] <= '0;
        cd_q[c] <= mbps_pkg::SAMP_RESET;
        bs_q[c] <= mbps_pkg::SAMP_RESET;
        held_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      case (st_q)
        S_IDLE: begin
          if (req_i.valid) begin
            rq_q <= req_i.data;
            ch_q <= '0;
            st_q <= S_CH;
          end
        end
        S_CH: begin
          bi_q <= '0;
          acc_q <= '0;
          prev_q <= '0;
          case (rq_q.action)
            mbps_pkg::ACT_APPEND: begin
              if (we) begin
                cnt_q[rq_ch] <= cnt_q[rq_ch] + 1'b1;
                fin_q[rq_ch] <= 1'b0;
                pos_q[rq_ch] <= '0;
                ch_q <= rq_ch;
                arm_pos_q <= '0;
                dv_q <= DV_SAMP;
                st_q <= S_RD;
              end else begin
                st_q <= S_IDLE;
              end
            end
            mbps_pkg::ACT_CLEAR: begin
              for (int c = 0; c < NUM_CHANNELS; c++) cnt_q[c] <= '0;
              st_q <= S_IDLE;
            end
            mbps_pkg::ACT_PLAY: begin
              running_q <= 1'b1;
              st_q <= S_IDLE;
            end
            mbps_pkg::ACT_PAUSE: begin
              running_q <= 1'b0;
              dnum_q <= PRW'({cd_q[ch_q], 15'd0});
              dden_q <= bs_q[ch_q];
              rem_q <= '0; dcnt_q <= PCW'(PRW);
              dv_q <= DV_PHASE;
              st_q <= (cd_q[ch_q] >= bs_q[ch_q]) ? S_FIN : S_DIV;
              quo_q <= (cd_q[ch_q] >= bs_q[ch_q]) ? PRW'(32767) : '0;
            end
            mbps_pkg::ACT_STOP: begin
              running_q <= 1'b0;
              fin_q[ch_q] <= 1'b0;
              held_q[ch_q] <= '0;
              pos_q[ch_q] <= '0;
              arm_pos_q <= '0;
              dv_q <= DV_SAMP;
              st_q <= S_RD;
            end
            mbps_pkg::ACT_SEEK: begin
              running_q <= 1'b0;
              st_q <= S_RD;
            end
            mbps_pkg::ACT_TICK: begin
              res_q.out_channel <= 3'(ch_q);
              res_q.last <= last_ch;
              if (!running_q) begin
                res_q.phase <= held_q[ch_q];
                res_q.beat_event <= 1'b0;
                st_q <= S_OUT; res_v_q <= 1'b1;
              end else if (fin_q[ch_q]) begin
                res_q.phase <= mbps_pkg::PHASE_DEAD;
                res_q.beat_event <= 1'b0;
                st_q <= S_OUT; res_v_q <= 1'b1;
              end else if (cd_q[ch_q] == '0) begin
                res_q.phase <= '0;
                res_q.beat_event <= 1'b1;
                if ({1'b0, pos_q[ch_q]} + 1'b1 < cnt_q[ch_q]) begin
                  arm_pos_q <= pos_q[ch_q] + 1'b1;
                  pos_q[ch_q] <= pos_q[ch_q] + 1'b1;
                end else begin
                  fin_q[ch_q] <= 1'b1;
                  arm_pos_q <= '0;
                  pos_q[ch_q] <= '0;
                end
                dv_q <= DV_SAMP;
                st_q <= S_RD;
              end else begin
                res_q.beat_event <= 1'b0;
                cd_q[ch_q] <= cd_q[ch_q] - 1'b1;
                dnum_q <= PRW'({cd_q[ch_q] - 1'b1, 15'd0});
                dden_q <= bs_q[ch_q];
                rem_q <= '0; dcnt_q <= PCW'(PRW);
                dv_q <= DV_PHASE;
                if (cd_q[ch_q] - 1'b1 >= bs_q[ch_q]) begin
                  quo_q <= PRW'(32767); st_q <= S_FIN;
                end else begin
                  quo_q <= '0; st_q <= S_DIV;
                end
              end
            end
            default: st_q <= S_IDLE;
          endcase
        end
        S_RD: begin
          if (rq_q.action == mbps_pkg::ACT_SEEK) begin
            if (bi_q < cnt_q[ch_q]) begin
              st_q <= S_SKACC;
            end else begin
              fin_q[ch_q] <= 1'b1;
              st_q <= S_NEXT;
            end
          end else begin
            st_q <= S_LD;
          end
        end
        S_LD: begin
          st_q <= S_MUL;
          mplier_q <= PRW'(beat_ms_rd);
          mcand_q <= PRW'(rate_q);
          prod_q <= '0;
          mcnt_q <= 6'd26;
        end
        S_SKACC: begin
          if (acc_nx > {1'b0, rq_q.position_ms}) begin
            // found: arm at bi, offset samples of goal-prev
            arm_pos_q <= bi_q[PW-1:0];
            pos_q[ch_q] <= bi_q[PW-1:0];
            fin_q[ch_q] <= 1'b0;
            mplier_q <= PRW'(beat_ms_rd);
            mcand_q <= PRW'(rate_q);
            prod_q <= '0;
            mcnt_q <= 6'd26;
            dv_q <= DV_SAMP;
            st_q <= S_MUL;
          end else begin
            acc_q <= acc_nx;
            prev_q <= acc_nx;
            bi_q <= bi_q + 1'b1;
            st_q <= S_RD;
          end
        end
        S_MUL: begin
          if (mplier_q[0]) prod_q <= prod_q + mcand_q;
          mplier_q <= mplier_q >> 1;
          mcand_q <= mcand_q << 1;
          mcnt_q <= mcnt_q - 1'b1;
          if (mcnt_q == 6'd1) begin
            st_q <= S_DIV;
            rem_q <= '0; quo_q <= '0; dcnt_q <= PCW'(PRW);
            dden_q <= SW'(mbps_pkg::MS_PER_SEC);
          end
        end
        S_DIV: begin
          if (mcnt_q == 6'd0 && dv_q != DV_PHASE && dcnt_q == PCW'(PRW)
              && quo_q == '0 && rem_q == '0) begin
            // load dividend from multiplier product
            dnum_q <= prod_q;
            mcnt_q <= 6'd63;
          end else begin
            rem_q <= ge ? rem_sh - (PRW+1)'(dden_q) : rem_sh;
            quo_q <= {quo_q[PRW-2:0], ge};
            dnum_q <= dnum_q << 1;
            dcnt_q <= dcnt_q - 1'b1;
            if (dcnt_q == PCW'(1)) st_q <= S_FIN;
          end
        end
        S_FIN: begin
          case (dv_q)
            DV_PHASE: begin
              if (rq_q.action == mbps_pkg::ACT_PAUSE) begin
                held_q[ch_q] <= ph_of_q;
                st_q <= S_NEXT;
              end else begin
                res_q.phase <= ph_of_q;
                res_v_q <= 1'b1;
                st_q <= S_OUT;
              end
            end
            DV_SAMP: begin
              bs_q[ch_q] <= samp_of_q;
              cd_q[ch_q] <= samp_of_q;
              if (rq_q.action == mbps_pkg::ACT_SEEK) begin
                sarm_q <= samp_of_q;
                mplier_q <= PRW'(rq_q.position_ms - prev_q[25:0]);
                mcand_q <= PRW'(rate_q);
                prod_q <= '0;
                mcnt_q <= 6'd26;
                dv_q <= DV_OFF;
                st_q <= S_MUL;
              end else if (rq_q.action == mbps_pkg::ACT_TICK) begin
                res_v_q <= 1'b1;
                st_q <= S_OUT;
              end else if (rq_q.action == mbps_pkg::ACT_STOP) begin
                st_q <= S_NEXT;
              end else begin
                st_q <= S_IDLE;
              end
            end
            default: begin
              cd_q[ch_q] <= (samp_of_q >= sarm_q) ? '0 : sarm_q - samp_of_q;
              st_q <= S_NEXT;
            end
          endcase
        end
        S_OUT: begin
          if (res_o.ready) begin
            res_v_q <= 1'b0;
            st_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (last_ch) begin
            st_q <= S_IDLE;
          end else begin
            ch_q <= ch_q + 1'b1;
            st_q <= S_CH;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/mbps_checker.sv
// Port-level checker for the sequencer, bound to the top level.
// Depends on mbps_pkg and the top level.
module mbps_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid, input logic in_ready,
  input logic out_valid, input logic out_ready,
  input mbps_pkg::res_t out_data
);
  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_no_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid) else $error("result right after request");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.last |-> out_data.out_channel == 3'd7)
    else $error("last on wrong channel");
  a_event_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.beat_event |-> out_data.phase == '0)
    else $error("event with nonzero phase");
endmodule

bind multichannel_beat_phasor_sequencer_unit mbps_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(req_i.valid), .in_ready(req_i.ready),
  .out_valid(res_o.valid), .out_ready(res_o.ready), .out_data(res_o.data)
);
